// ----- hdl/adc_window_median_trimmed_mean_assert.svh -----
// Assertion macros used by the filter's top-level RTL file.
`ifndef ADC_WINDOW_MEDIAN_TRIMMED_MEAN_ASSERT_SVH
`define ADC_WINDOW_MEDIAN_TRIMMED_MEAN_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define AWMTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by another on the next clock edge.
`define AWMTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/awmtm_pkg.sv -----
// Shared constants, codes and types of the window median / trimmed-mean filter.
`default_nettype none

package awmtm_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int OUT_W          = 14;
    localparam int OUT_MAX        = 16383;
    localparam int WINDOW_DEF     = 16;
    localparam int FIFO_DEPTH_DEF = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 2;

    typedef enum logic [1:0] {
        ACT_STORE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [1:0] MODE_MEDIAN = 2'd0;
    localparam logic [1:0] MODE_OVERS  = 2'd1;
    localparam logic [1:0] MODE_RESET  = 2'd1;
    localparam logic [1:0] OB_RESET    = 2'd2;
    localparam logic [1:0] OB_MAX      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE  = 1'd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] ob;
    } t_rd_ctl;

    localparam int CTL_W = $bits(t_rd_ctl);

endpackage

`default_nettype wire

// ----- hdl/awmtm_req_if.sv -----
// Request channel: action code and converter sample.
`default_nettype none

interface awmtm_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        action;
    logic [awmtm_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

// ----- hdl/awmtm_rsp_if.sv -----
// Response channel: filtered value.
`default_nettype none

interface awmtm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [awmtm_pkg::OUT_W-1:0]    filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ----- hdl/awmtm_front.sv -----
// Front end: sample ring, sorted cell chain, configuration and request decode.
`default_nettype none

module awmtm_front #(
    parameter  int WINDOW  = awmtm_pkg::WINDOW_DEF,
    localparam int LO      = WINDOW / 4,
    localparam int COUNT   = WINDOW - 2 * LO,
    localparam int MIDS_W  = COUNT * awmtm_pkg::SAMPLE_W,
    localparam int ENTRY_W = awmtm_pkg::CTL_W + awmtm_pkg::SAMPLE_W + MIDS_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    awmtm_req_if.sink                           i_req,
    input  logic                                i_cfg_wr_en,
    input  logic [awmtm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [awmtm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                i_full,
    output logic                                o_push,
    output logic [ENTRY_W-1:0]                  o_push_data
);

    localparam int SW     = awmtm_pkg::SAMPLE_W;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int MED    = (WINDOW - 1) / 2;

    logic [SW-1:0]      r_ring   [WINDOW];
    logic [SW-1:0]      r_sorted [WINDOW];
    logic [SLOT_W-1:0]  r_slot;
    logic [1:0]         r_mode;
    logic [1:0]         r_ob;

    awmtm_pkg::t_action w_act;
    awmtm_pkg::t_rd_ctl w_ctl;
    logic               w_acc;
    logic [SW-1:0]      w_old;
    logic [SW-1:0]      w_new;
    logic [WINDOW-1:0]  w_eq;
    logic [WINDOW-1:0]  w_rm;
    logic [WINDOW-1:0]  w_lt;
    logic [SW-1:0]      w_a   [WINDOW];
    logic [SW-1:0]      w_ins [WINDOW];
    logic [MIDS_W-1:0]  w_mids;

    assign w_act       = awmtm_pkg::t_action'(i_req.action);
    assign i_req.ready = !i_full;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_old       = r_ring[r_slot];
    assign w_new       = i_req.sample;

    // Each cell drops the first copy of the outgoing sample, then the
    // incoming sample drops into place where the chain stops being smaller.
    genvar g;
    for (g = 0; g < WINDOW; g++) begin : g_cell
        assign w_eq[g] = (r_sorted[g] == w_old);
        assign w_rm[g] = |w_eq[g:0];
        if (g < WINDOW - 1) begin : g_mid
            assign w_a[g]  = w_rm[g] ? r_sorted[g+1] : r_sorted[g];
            assign w_lt[g] = (w_a[g] < w_new);
        end else begin : g_last
            assign w_a[g]  = r_sorted[g];
            assign w_lt[g] = 1'b0;
        end
        if (g == 0) begin : g_first
            assign w_ins[g] = w_lt[g] ? w_a[g] : w_new;
        end else begin : g_rest
            assign w_ins[g] = w_lt[g] ? w_a[g] : (w_lt[g-1] ? w_new : w_a[g-1]);
        end
    end

    for (g = 0; g < COUNT; g++) begin : g_pack
        assign w_mids[g*SW +: SW] = r_sorted[LO+g];
    end

    assign w_ctl       = '{mode: r_mode, ob: r_ob};
    assign o_push      = w_acc && (w_act == awmtm_pkg::ACT_READ);
    assign o_push_data = {w_ctl, r_sorted[MED], w_mids};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= awmtm_pkg::MODE_RESET;
            r_ob   <= awmtm_pkg::OB_RESET;
            r_slot <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i]   <= '0;
                r_sorted[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    awmtm_pkg::REG_FILTER_MODE: r_mode <= i_cfg_wdata;
                    awmtm_pkg::REG_OVERSAMPLE:  r_ob   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_acc) begin
                unique case (w_act)
                    awmtm_pkg::ACT_STORE: begin
                        r_ring[r_slot] <= w_new;
                        for (int i = 0; i < WINDOW; i++) begin
                            r_sorted[i] <= w_ins[i];
                        end
                        r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    end
                    awmtm_pkg::ACT_CLEAR: begin
                        r_slot <= '0;
                        for (int i = 0; i < WINDOW; i++) begin
                            r_ring[i]   <= '0;
                            r_sorted[i] <= '0;
                        end
                    end
                    awmtm_pkg::ACT_READ, awmtm_pkg::ACT_NONE: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/awmtm_fifo.sv -----
// Short queue of read snapshots between the front end and the arithmetic unit.
`default_nettype none

module awmtm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = awmtm_pkg::FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic w_do_push;
    logic w_do_pop;

    assign o_full      = (r_cnt == CNT_W'(DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_data  = r_mem[r_rp];
    assign w_do_push   = i_push && !o_full;
    assign w_do_pop    = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/awmtm_back.sv -----
// Arithmetic unit: median pass-through, serial trimmed sum, restoring divider and output register.
`default_nettype none

module awmtm_back #(
    parameter  int WINDOW  = awmtm_pkg::WINDOW_DEF,
    localparam int LO      = WINDOW / 4,
    localparam int COUNT   = WINDOW - 2 * LO,
    localparam int MIDS_W  = COUNT * awmtm_pkg::SAMPLE_W,
    localparam int ENTRY_W = awmtm_pkg::CTL_W + awmtm_pkg::SAMPLE_W + MIDS_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  logic [ENTRY_W-1:0] i_q_data,
    output logic               o_q_pop,
    awmtm_rsp_if.source        o_rsp
);

    localparam int SMP_W   = awmtm_pkg::SAMPLE_W;
    localparam int OUT_W   = awmtm_pkg::OUT_W;
    localparam int SW      = $clog2(COUNT * ((1 << SMP_W) - 1) + 1);
    localparam int DW      = $clog2(COUNT + 1);
    localparam int CNT_MAX = (COUNT > SW) ? COUNT : SW;
    localparam int CNT_W   = $clog2(CNT_MAX);

    typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DIV} t_state;

    t_state             r_state;
    logic [MIDS_W-1:0]  r_mids;
    logic [SW-1:0]      r_acc;
    logic [DW-1:0]      r_rem;
    logic [DW-1:0]      r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    awmtm_pkg::t_rd_ctl w_ctl;
    logic [SMP_W-1:0]   w_med;
    logic [MIDS_W-1:0]  w_mids;
    logic [1:0]         w_ob_eff;
    logic [DW-1:0]      w_div_raw;
    logic [DW-1:0]      w_div;
    logic [SW-1:0]      w_sum_nx;
    logic [DW:0]        w_rem_sh;
    logic               w_ge;
    logic [DW:0]        w_rem_diff;
    logic [DW-1:0]      w_rem_nx;
    logic [SW-1:0]      w_quo_nx;

    assign w_ctl  = i_q_data[ENTRY_W-1 -: awmtm_pkg::CTL_W];
    assign w_med  = i_q_data[MIDS_W +: SMP_W];
    assign w_mids = i_q_data[MIDS_W-1:0];

    // Mode 1 keeps extra resolution by dividing by a smaller count.
    assign w_ob_eff  = (w_ctl.ob > awmtm_pkg::OB_MAX) ? awmtm_pkg::OB_MAX : w_ctl.ob;
    assign w_div_raw = (w_ctl.mode == awmtm_pkg::MODE_OVERS) ? DW'(COUNT >> w_ob_eff)
                                                             : DW'(COUNT);
    assign w_div     = (w_div_raw == '0) ? DW'(1) : w_div_raw;

    assign w_sum_nx   = r_acc + SW'(r_mids[SMP_W-1:0]);
    assign w_rem_sh   = {r_rem, r_acc[SW-1]};
    assign w_ge       = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_diff = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
    assign w_rem_nx   = w_rem_diff[DW-1:0];
    assign w_quo_nx   = {r_acc[SW-2:0], w_ge};

    assign o_q_pop        = (r_state == ST_IDLE) && i_q_valid && !r_out_valid;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.filtered = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        if (w_ctl.mode == awmtm_pkg::MODE_MEDIAN) begin
                            r_out_data  <= OUT_W'(w_med);
                            r_out_valid <= 1'b1;
                        end else begin
                            r_mids  <= w_mids;
                            r_div   <= w_div;
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    r_mids <= r_mids >> SMP_W;
                    r_acc  <= w_sum_nx;
                    if (r_cnt == CNT_W'(COUNT - 1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DIV: begin
                    r_acc <= w_quo_nx;
                    r_rem <= w_rem_nx;
                    if (r_cnt == CNT_W'(SW - 1)) begin
                        r_cnt       <= '0;
                        r_out_valid <= 1'b1;
                        r_out_data  <= (w_quo_nx > SW'(awmtm_pkg::OUT_MAX))
                                       ? OUT_W'(awmtm_pkg::OUT_MAX) : w_quo_nx[OUT_W-1:0];
                        r_state     <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/adc_window_median_trimmed_mean.sv -----
// Stores and clears take effect at acceptance, one per cycle unless stalled.
// An accepted read is queued as a snapshot; a median read then goes to the output
// register directly; a trimmed-mean read first takes COUNT serial adds (COUNT =
// WINDOW - 2*(WINDOW/4)) and SW quotient bits in the restoring divider.
// Up to FIFO_DEPTH (default 2) reads wait queued; requests stall only when full.
// Synchronous active-low reset zeroes the window and slot, mode 1, oversample 2.
`default_nettype none

`include "adc_window_median_trimmed_mean_assert.svh"

module adc_window_median_trimmed_mean #(
    parameter  int WINDOW     = awmtm_pkg::WINDOW_DEF,
    parameter  int FIFO_DEPTH = awmtm_pkg::FIFO_DEPTH_DEF,
    localparam int LO         = WINDOW / 4,
    localparam int COUNT      = WINDOW - 2 * LO,
    localparam int ENTRY_W    = awmtm_pkg::CTL_W + awmtm_pkg::SAMPLE_W
                                + COUNT * awmtm_pkg::SAMPLE_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    awmtm_req_if.sink                           i_req,
    awmtm_rsp_if.source                         o_rsp,
    input  logic                                i_cfg_wr_en,
    input  logic [awmtm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [awmtm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    logic               w_push;
    logic [ENTRY_W-1:0] w_push_data;
    logic               w_full;
    logic               w_q_valid;
    logic [ENTRY_W-1:0] w_q_data;
    logic               w_q_pop;
    logic               w_rd_acc;

    awmtm_front #(.WINDOW(WINDOW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    awmtm_fifo #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_pop_valid (w_q_valid),
        .o_pop_data  (w_q_data),
        .i_pop       (w_q_pop)
    );

    awmtm_back #(.WINDOW(WINDOW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_rsp     (o_rsp)
    );

    assign w_rd_acc = i_req.valid && i_req.ready && (i_req.action == awmtm_pkg::ACT_READ);

    // A stalled request side means reads are waiting in the queue.
    `AWMTM_ASSERT(a_stall_only_when_queued, !i_req.ready |-> w_q_valid, "stall without queued reads")
    // The arithmetic unit takes a new read only into an empty output register.
    `AWMTM_ASSERT(a_pop_into_free_out, w_q_pop |-> !o_rsp.valid, "pop over pending result")
    // An accepted read request is queued by the next cycle.
    `AWMTM_ASSERT_NEXT(a_read_queued, w_rd_acc, w_q_valid, "accepted read request not queued")

endmodule

`default_nettype wire
